>>> rtl/pwjq_pkg.sv
// ----------------------------------------------------------------------------
// pwjq_pkg: shared definitions for the per-worker job queue
// Sizes, status codes, payload structs and the controller/datapath interface.
// ----------------------------------------------------------------------------
package pwjq_pkg;

    localparam int NUM_WORKERS  = 8;
    localparam int LOCAL_DEPTH  = 32;
    localparam int GLOBAL_DEPTH = 256;
    localparam int JOB_WIDTH    = 32;

    localparam int WIDX_W     = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int LPTR_W     = $clog2(LOCAL_DEPTH);
    localparam int LCNT_W     = $clog2(LOCAL_DEPTH + 1);
    localparam int LMEM_DEPTH = NUM_WORKERS * LOCAL_DEPTH;
    localparam int LADDR_W    = $clog2(LMEM_DEPTH);
    localparam int GPTR_W     = $clog2(GLOBAL_DEPTH);
    localparam int GCNT_W     = $clog2(GLOBAL_DEPTH + 1);

    // Configuration register file
    localparam int APB_ADDR_W  = 3;
    localparam int LIMIT_W     = 6;
    localparam int PERIOD_W    = 8;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 6'd32;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd20;
    localparam logic REG_LOCAL_LIMIT  = 1'b0;
    localparam logic REG_CHECK_PERIOD = 1'b1;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_PUSH_LOCAL  = 3'd0,
        ST_PUSH_GLOBAL = 3'd1,
        ST_PUSH_DROP   = 3'd2,
        ST_POP_LOCAL   = 3'd3,
        ST_POP_GLOBAL  = 3'd4,
        ST_EMPTY       = 3'd5
    } t_status;

    typedef struct packed {
        logic        action;
        logic [2:0]  worker;
        logic [31:0] job;
    } t_in;

    typedef struct packed {
        logic [31:0] job_out;
        t_status     status;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_req;
        logic exec;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/pwjq_ctrl.sv
// ----------------------------------------------------------------------------
// pwjq_ctrl: request sequencer
// Steps each request through capture, decision and result hand-over.
// ----------------------------------------------------------------------------
module pwjq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  pwjq_pkg::t_dp_sts i_sts,
    output logic              o_in_stall,
    output pwjq_pkg::t_cmd    o_cmd
);
    import pwjq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   take;

    // A new request may enter while the previous result is handed over.
    assign take = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = take ? S_DECIDE : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall     = 1'b1;
        o_cmd.exec     = 1'b0;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
            end
            S_DECIDE: begin
                o_cmd.exec = 1'b1;
            end
            S_DONE: begin
                o_in_stall     = !i_sts.out_free;
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
        o_cmd.load_req = i_in_valid && !o_in_stall;
    end

endmodule

>>> rtl/pwjq_dp.sv
// ----------------------------------------------------------------------------
// pwjq_dp: queue datapath
// Per-worker pointers and counters, the two job memories and the result register.
// ----------------------------------------------------------------------------
module pwjq_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pwjq_pkg::t_in                  i_in_data,
    input  logic [pwjq_pkg::LIMIT_W-1:0]   i_local_limit,
    input  logic [pwjq_pkg::PERIOD_W-1:0]  i_check_period,
    input  pwjq_pkg::t_cmd                 i_cmd,
    input  logic                           i_out_stall,
    output pwjq_pkg::t_dp_sts              o_sts,
    output logic                           o_out_valid,
    output pwjq_pkg::t_out                 o_out_data
);
    import pwjq_pkg::*;

    t_in                 r_req;
    logic [LPTR_W-1:0]   r_lhead [NUM_WORKERS];
    logic [LPTR_W-1:0]   r_ltail [NUM_WORKERS];
    logic [LCNT_W-1:0]   r_lcount [NUM_WORKERS];
    logic [PERIOD_W-1:0] r_pops [NUM_WORKERS];
    logic [GPTR_W-1:0]   r_ghead;
    logic [GPTR_W-1:0]   r_gtail;
    logic [GCNT_W-1:0]   r_gcount;

    logic [JOB_WIDTH-1:0] r_lmem [LMEM_DEPTH];
    logic [JOB_WIDTH-1:0] r_gmem [GLOBAL_DEPTH];
    logic [JOB_WIDTH-1:0] r_lrd;
    logic [JOB_WIDTH-1:0] r_grd;

    t_status r_res_status;
    logic    r_out_valid;
    t_out    r_out;

    logic [WIDX_W-1:0]   w_idx;
    logic                w_ok;
    logic [LPTR_W-1:0]   lhead;
    logic [LPTR_W-1:0]   ltail;
    logic [LCNT_W-1:0]   lcount;
    logic [PERIOD_W-1:0] pops_inc;
    logic [LCNT_W-1:0]   lim;
    logic                check;
    logic                lnz;
    logic                gnz;
    logic                l_wr;
    logic                g_wr;
    logic                l_rd;
    logic                g_rd;
    logic [LADDR_W-1:0]  l_base;
    t_status             n_status;

    function automatic logic [LPTR_W-1:0] lwrap(input logic [LPTR_W-1:0] p);
        return (32'(p) == LOCAL_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [GPTR_W-1:0] gwrap(input logic [GPTR_W-1:0] p);
        return (32'(p) == GLOBAL_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) r_req <= i_in_data;
    end

    assign w_idx    = WIDX_W'(r_req.worker);
    assign w_ok     = 32'(r_req.worker) < NUM_WORKERS;
    assign lhead    = r_lhead[w_idx];
    assign ltail    = r_ltail[w_idx];
    assign lcount   = r_lcount[w_idx];
    assign pops_inc = r_pops[w_idx] + 1'b1;
    assign lim      = (32'(i_local_limit) > LOCAL_DEPTH) ? LCNT_W'(LOCAL_DEPTH)
                                                         : LCNT_W'(i_local_limit);
    assign check    = pops_inc == i_check_period;
    assign lnz      = lcount != '0;
    assign gnz      = r_gcount != '0;
    assign l_base   = LADDR_W'(w_idx) * LADDR_W'(LOCAL_DEPTH);

    // Decision for the captured request. A forced check that finds the
    // global queue empty falls through to the local queue.
    always_comb begin
        l_wr     = 1'b0;
        g_wr     = 1'b0;
        l_rd     = 1'b0;
        g_rd     = 1'b0;
        n_status = ST_EMPTY;
        if (!w_ok) begin
            n_status = (r_req.action == ACT_POP) ? ST_EMPTY : ST_PUSH_DROP;
        end else if (r_req.action == ACT_PUSH) begin
            if (lcount < lim) begin
                l_wr     = 1'b1;
                n_status = ST_PUSH_LOCAL;
            end else if (32'(r_gcount) < GLOBAL_DEPTH) begin
                g_wr     = 1'b1;
                n_status = ST_PUSH_GLOBAL;
            end else begin
                n_status = ST_PUSH_DROP;
            end
        end else begin
            if (gnz && (check || !lnz)) begin
                g_rd     = 1'b1;
                n_status = ST_POP_GLOBAL;
            end else if (lnz) begin
                l_rd     = 1'b1;
                n_status = ST_POP_LOCAL;
            end else begin
                n_status = ST_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WORKERS; i++) begin
                r_lhead[i]  <= '0;
                r_ltail[i]  <= '0;
                r_lcount[i] <= '0;
                r_pops[i]   <= '0;
            end
            r_ghead  <= '0;
            r_gtail  <= '0;
            r_gcount <= '0;
        end else if (i_cmd.exec && w_ok) begin
            if (l_wr) begin
                r_ltail[w_idx]  <= lwrap(ltail);
                r_lcount[w_idx] <= lcount + 1'b1;
            end
            if (l_rd) begin
                r_lhead[w_idx]  <= lwrap(lhead);
                r_lcount[w_idx] <= lcount - 1'b1;
            end
            if (g_wr) begin
                r_gtail  <= gwrap(r_gtail);
                r_gcount <= r_gcount + 1'b1;
            end
            if (g_rd) begin
                r_ghead  <= gwrap(r_ghead);
                r_gcount <= r_gcount - 1'b1;
            end
            if (r_req.action == ACT_POP) begin
                r_pops[w_idx] <= (check || !lnz) ? '0 : pops_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && l_wr) r_lmem[l_base + LADDR_W'(ltail)] <= JOB_WIDTH'(r_req.job);
        if (i_cmd.exec && l_rd) r_lrd <= r_lmem[l_base + LADDR_W'(lhead)];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && g_wr) r_gmem[r_gtail] <= JOB_WIDTH'(r_req.job);
        if (i_cmd.exec && g_rd) r_grd <= r_gmem[r_ghead];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) r_res_status <= n_status;
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.status <= r_res_status;
            unique case (r_res_status)
                ST_POP_LOCAL:  r_out.job_out <= 32'(r_lrd);
                ST_POP_GLOBAL: r_out.job_out <= 32'(r_grd);
                default:       r_out.job_out <= '0;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/per_worker_job_queue_with_overflow.sv
// ----------------------------------------------------------------------------
// per_worker_job_queue_with_overflow: worker job queues with shared overflow
// Top level: configuration registers, request sequencer and queue datapath.
// ----------------------------------------------------------------------------
// Each request on the input channel is a push or a pop for one worker. A
// push lands in the worker's local queue while it holds fewer jobs than
// local_limit, otherwise in the shared global queue, and is dropped when
// that is full too. A pop takes the worker's oldest local job, except that
// every check_period-th pop, or any pop on an empty local queue, looks at
// the global queue first. Every request gives exactly one result transfer
// carrying the popped job (zero when there is none) and a status code.
//
// A request is transferred when i_in_valid is high and o_in_stall is low.
// The request register captures it at the transfer; then the pointers are
// updated and the job memories read, and then the output register is loaded
// and raises o_out_valid, once no stalled result is still held there.
// Requests are handled one at a time, and the next one is taken in the
// cycle its predecessor's result is loaded, so each request waits for the
// pointer update and the output load of the one before it.
// While the receiver stalls, the result stays in the output register and
// the next request waits in the sequencer after its memory access.
// Reset empties every queue and clears the check counters at once; the job
// memories need no clearing. The user writes local_limit and check_period
// at APB byte addresses 0 and 4 only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module per_worker_job_queue_with_overflow (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  pwjq_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output pwjq_pkg::t_out                  o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pwjq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import pwjq_pkg::*;

    logic [LIMIT_W-1:0]  r_local_limit;
    logic [PERIOD_W-1:0] r_check_period;
    logic                cfg_wr;
    t_cmd                cmd;
    t_dp_sts             dp_sts;

    // The register file answers in the access cycle, so pready is tied high.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_limit  <= LIMIT_RESET;
            r_check_period <= PERIOD_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_LOCAL_LIMIT:  r_local_limit  <= pwdata[LIMIT_W-1:0];
                REG_CHECK_PERIOD: r_check_period <= pwdata[PERIOD_W-1:0];
                default:          r_local_limit  <= r_local_limit;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LOCAL_LIMIT:  prdata = 32'(r_local_limit);
            REG_CHECK_PERIOD: prdata = 32'(r_check_period);
            default:          prdata = '0;
        endcase
    end

    // The sequencer decides when a request is captured, executed and
    // handed over; the datapath holds all queue state and the result.
    pwjq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (dp_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    pwjq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_data      (i_in_data),
        .i_local_limit  (r_local_limit),
        .i_check_period (r_check_period),
        .i_cmd          (cmd),
        .i_out_stall    (i_out_stall),
        .o_sts          (dp_sts),
        .o_out_valid    (o_out_valid),
        .o_out_data     (o_out_data)
    );

endmodule

>>> rtl/pwjq_checker.sv
// ----------------------------------------------------------------------------
// pwjq_checker: port-level checks for the per-worker job queue
// Watches the top-level channels and is bound to the top level.
// ----------------------------------------------------------------------------
module pwjq_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input pwjq_pkg::t_out o_out_data
);
    import pwjq_pkg::*;

    // A held result must not change while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Every accepted request is followed by a valid result on o_out_valid.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> ##3 o_out_valid)
        else $error("no result three cycles after a request transfer");

    // Only pops that found a job carry a job handle.
    a_zero_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_PUSH_LOCAL
                     || o_out_data.status == ST_PUSH_GLOBAL
                     || o_out_data.status == ST_PUSH_DROP
                     || o_out_data.status == ST_EMPTY)
        |-> o_out_data.job_out == '0)
        else $error("non-pop result carries a job");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind per_worker_job_queue_with_overflow pwjq_checker u_pwjq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
